@@ hw/rtl/jse_pkg.sv @@
package jse_pkg;

  // Characters that the escaper writes on its own.
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_U      = 8'h75;

  // Limits for UTF-8 validation.
  localparam logic [7:0]  LEAD_MIN    = 8'hC2;
  localparam logic [7:0]  LEAD_MAX    = 8'hF4;
  localparam logic [7:0]  CONT_MASK   = 8'hC0;
  localparam logic [20:0] CP_MIN3     = 21'h000800;
  localparam logic [20:0] CP_MIN4     = 21'h010000;
  localparam logic [20:0] CP_MAX      = 21'h10FFFF;
  localparam logic [20:0] CP_SURR_LO  = 21'h00D800;
  localparam logic [20:0] CP_SURR_HI  = 21'h00DFFF;
  localparam logic [20:0] CP_LSEP     = 21'h002028;
  localparam logic [20:0] CP_PSEP     = 21'h002029;
  localparam logic [15:0] CODE_REPL   = 16'hFFFD;

  // What follows the replacement escapes of one job.
  typedef enum logic [2:0] {
    TK_NONE  = 3'd0,
    TK_RAW   = 3'd1,
    TK_SHORT = 3'd2,
    TK_UESC  = 3'd3,
    TK_CLOSE = 3'd4
  } tail_kind_t;

  typedef struct packed {
    tail_kind_t  kind;
    logic [2:0]  len;   // byte count for raw bytes
    logic [31:0] data;  // raw bytes (first in the low byte), short char or code
  } tail_t;

  // One classified input item: everything the back end needs to expand it.
  typedef struct packed {
    logic       quote_open;
    logic [2:0] fffd_cnt;
    tail_t      tail;
  } job_t;

  function automatic logic [7:0] hex_char(logic [3:0] nib);
    logic [7:0] c;
    if (nib < 4'd10) begin
      c = 8'h30 + {4'h0, nib};
    end else begin
      c = 8'h37 + {4'h0, nib};
    end
    return c;
  endfunction

  // Byte k of a six-byte \uXXXX escape.
  function automatic logic [7:0] uesc_char(logic [15:0] code, logic [2:0] k);
    logic [7:0] c;
    unique case (k)
      3'd0:    c = CH_BSLASH;
      3'd1:    c = CH_U;
      3'd2:    c = hex_char(code[15:12]);
      3'd3:    c = hex_char(code[11:8]);
      3'd4:    c = hex_char(code[7:4]);
      default: c = hex_char(code[3:0]);
    endcase
    return c;
  endfunction

  // Length of a UTF-8 sequence given its lead byte, zero when invalid.
  function automatic logic [2:0] lead_len(logic [7:0] b);
    logic [2:0] n;
    if (b >= LEAD_MIN && b <= 8'hDF) begin
      n = 3'd2;
    end else if (b >= 8'hE0 && b <= 8'hEF) begin
      n = 3'd3;
    end else if (b >= 8'hF0 && b <= LEAD_MAX) begin
      n = 3'd4;
    end else begin
      n = 3'd0;
    end
    return n;
  endfunction

  // Escape class of an ASCII byte.
  function automatic tail_t ascii_tail(logic [7:0] b);
    tail_t t;
    t.kind = TK_RAW;
    t.len  = 3'd1;
    t.data = {24'h0, b};
    unique case (b)
      8'h22: begin t.kind = TK_SHORT; t.data = {24'h0, CH_QUOTE}; end
      8'h5C: begin t.kind = TK_SHORT; t.data = {24'h0, CH_BSLASH}; end
      8'h08: begin t.kind = TK_SHORT; t.data = {24'h0, 8'h62}; end
      8'h0C: begin t.kind = TK_SHORT; t.data = {24'h0, 8'h66}; end
      8'h0A: begin t.kind = TK_SHORT; t.data = {24'h0, 8'h6E}; end
      8'h0D: begin t.kind = TK_SHORT; t.data = {24'h0, 8'h72}; end
      8'h09: begin t.kind = TK_SHORT; t.data = {24'h0, 8'h74}; end
      8'h3C, 8'h3E, 8'h26: begin
        t.kind = TK_UESC;
      end
      default: begin
        if (b < 8'h20) begin
          t.kind = TK_UESC;
        end
      end
    endcase
    return t;
  endfunction

  function automatic logic [2:0] tail_len(tail_t t);
    logic [2:0] n;
    unique case (t.kind)
      TK_RAW:   n = t.len;
      TK_SHORT: n = 3'd2;
      TK_UESC:  n = 3'd6;
      TK_CLOSE: n = 3'd1;
      default:  n = 3'd0;
    endcase
    return n;
  endfunction

endpackage

@@ hw/rtl/jse_front.sv @@
module jse_front
  import jse_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_push,
  input  logic       in_action,
  input  logic [7:0] in_data_byte,
  input  logic       jq_full,
  output logic       jq_push,
  output job_t       jq_job
);

  logic [7:0] pend_r [3];
  logic [1:0] pc_r, pc_nxt;
  logic [2:0] exp_r, exp_nxt;
  logic       open_r, open_nxt;

  logic        accept;
  logic        fresh;
  logic        store;
  logic        is_cont;
  logic [2:0]  ld_len;
  logic [20:0] cp;
  logic        cp_ok;
  job_t        job;

  assign accept  = in_push && !jq_full;
  assign is_cont = (in_data_byte & CONT_MASK) == 8'h80;
  assign ld_len  = lead_len(in_data_byte);

  // Code point of the sequence that this byte completes.
  always_comb begin
    unique case (exp_r)
      3'd2:    cp = {10'h0, pend_r[0][4:0], in_data_byte[5:0]};
      3'd3:    cp = {5'h0, pend_r[0][3:0], pend_r[1][5:0], in_data_byte[5:0]};
      3'd4:    cp = {pend_r[0][2:0], pend_r[1][5:0], pend_r[2][5:0], in_data_byte[5:0]};
      default: cp = '0;
    endcase
  end

  assign cp_ok = !((exp_r == 3'd2 && cp < 21'h80) || (exp_r == 3'd3 && cp < CP_MIN3) ||
                   (exp_r == 3'd4 && cp < CP_MIN4)) &&
                 (cp <= CP_MAX) && !(cp >= CP_SURR_LO && cp <= CP_SURR_HI);

  always_comb begin
    job            = '0;
    job.quote_open = !open_r;
    job.tail.kind  = TK_NONE;
    pc_nxt         = pc_r;
    exp_nxt        = exp_r;
    open_nxt       = open_r;
    fresh          = 1'b0;
    store          = 1'b0;
    if (in_action) begin
      job.fffd_cnt  = {1'b0, pc_r};
      job.tail.kind = TK_CLOSE;
      pc_nxt        = 2'd0;
      exp_nxt       = 3'd0;
      open_nxt      = 1'b0;
    end else begin
      open_nxt = 1'b1;
      if (pc_r != 2'd0) begin
        if (is_cont) begin
          if ({1'b0, pc_r} + 3'd1 == exp_r) begin
            pc_nxt  = 2'd0;
            exp_nxt = 3'd0;
            if (!cp_ok) begin
              job.fffd_cnt = exp_r;
            end else if (cp == CP_LSEP || cp == CP_PSEP) begin
              job.tail.kind = TK_UESC;
              job.tail.data = {16'h0, cp[15:0]};
            end else begin
              job.tail.kind = TK_RAW;
              job.tail.len  = exp_r;
              unique case (exp_r)
                3'd2:    job.tail.data = {16'h0, in_data_byte, pend_r[0]};
                3'd3:    job.tail.data = {8'h0, in_data_byte, pend_r[1], pend_r[0]};
                default: job.tail.data = {in_data_byte, pend_r[2], pend_r[1], pend_r[0]};
              endcase
            end
          end else begin
            store  = 1'b1;
            pc_nxt = pc_r + 2'd1;
          end
        end else begin
          job.fffd_cnt = {1'b0, pc_r};
          pc_nxt       = 2'd0;
          exp_nxt      = 3'd0;
          fresh        = 1'b1;
        end
      end else begin
        fresh = 1'b1;
      end
      if (fresh) begin
        if (!in_data_byte[7]) begin
          job.tail = ascii_tail(in_data_byte);
        end else if (ld_len == 3'd0) begin
          job.fffd_cnt = job.fffd_cnt + 3'd1;
        end else begin
          store   = 1'b1;
          pc_nxt  = 2'd1;
          exp_nxt = ld_len;
        end
      end
    end
  end

  // A step that only holds a byte has nothing for the back end unless it opens the string.
  assign jq_job  = job;
  assign jq_push = accept &&
                   (job.quote_open || job.fffd_cnt != 3'd0 || job.tail.kind != TK_NONE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r   <= 2'd0;
      exp_r  <= 3'd0;
      open_r <= 1'b0;
    end else if (accept) begin
      pc_r   <= pc_nxt;
      exp_r  <= exp_nxt;
      open_r <= open_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && store) begin
      if (fresh) begin
        pend_r[0] <= in_data_byte;
      end else begin
        pend_r[pc_r] <= in_data_byte;
      end
    end
  end

`ifndef SYNTHESIS
  a_pend_below_len: assert property (@(posedge clk) disable iff (!rst_n)
    pc_r != 2'd0 |-> ({1'b0, pc_r} < exp_r && open_r))
    else $error("held bytes without a matching sequence length");
`endif

endmodule

@@ hw/rtl/jse_jobq.sv @@
module jse_jobq
  import jse_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_job,
  output logic full,
  input  logic pop,
  output job_t head_job,
  output logic empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  job_t          mem_r [DEPTH];
  logic [AW-1:0] wr_r, rd_r;
  logic [CW-1:0] cnt_r;
  logic          do_push, do_pop;

  assign full     = cnt_r == CW'(DEPTH);
  assign empty    = cnt_r == '0;
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign head_job = mem_r[rd_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) begin
        wr_r <= (wr_r == AW'(DEPTH - 1)) ? '0 : wr_r + 1'b1;
      end
      if (do_pop) begin
        rd_r <= (rd_r == AW'(DEPTH - 1)) ? '0 : rd_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_r] <= push_job;
    end
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(DEPTH))
    else $error("job queue count beyond its depth");
`endif

endmodule

@@ hw/rtl/jse_back.sv @@
module jse_back
  import jse_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       jq_empty,
  input  job_t       jq_head,
  output logic       jq_pop,
  input  logic       out_pop,
  output logic       out_empty,
  output logic [7:0] out_out_byte,
  output logic       out_last_of_run
);

  localparam logic [1:0] PH_OPEN = 2'd0;
  localparam logic [1:0] PH_FFFD = 2'd1;
  localparam logic [1:0] PH_TAIL = 2'd2;

  job_t       job_r, job_nxt;
  logic       busy_r, busy_nxt;
  logic [1:0] phase_r, phase_nxt;
  logic [2:0] k_r, k_nxt;
  logic [2:0] fleft_r, fleft_nxt;

  logic       emit;
  logic       last;
  logic [7:0] ebyte;
  logic [2:0] tlen;
  logic       load;

  // Two-entry output buffer.
  logic [7:0] ob_byte_r [2];
  logic       ob_last_r [2];
  logic       owr_r, ord_r;
  logic [1:0] ocnt_r;
  logic       do_opop;

  assign tlen = tail_len(job_r.tail);
  assign emit = busy_r && (ocnt_r != 2'd2);

  always_comb begin
    ebyte = CH_QUOTE;
    last  = 1'b0;
    unique case (phase_r)
      PH_OPEN: begin
        ebyte = CH_QUOTE;
        last  = (job_r.fffd_cnt == 3'd0) && (tlen == 3'd0);
      end
      PH_FFFD: begin
        ebyte = uesc_char(CODE_REPL, k_r);
        last  = (k_r == 3'd5) && (fleft_r == 3'd1) && (tlen == 3'd0);
      end
      PH_TAIL: begin
        last = k_r == tlen - 3'd1;
        unique case (job_r.tail.kind)
          TK_RAW:   ebyte = job_r.tail.data[{k_r[1:0], 3'b000} +: 8];
          TK_SHORT: ebyte = (k_r == 3'd0) ? CH_BSLASH : job_r.tail.data[7:0];
          TK_UESC:  ebyte = uesc_char(job_r.tail.data[15:0], k_r);
          default:  ebyte = CH_QUOTE;
        endcase
      end
      default: begin
        ebyte = CH_QUOTE;
        last  = 1'b1;
      end
    endcase
  end

  // The next job is taken in the same cycle as the last byte of the current one.
  assign load   = !jq_empty && (!busy_r || (emit && last));
  assign jq_pop = load;

  always_comb begin
    job_nxt   = job_r;
    busy_nxt  = busy_r;
    phase_nxt = phase_r;
    k_nxt     = k_r;
    fleft_nxt = fleft_r;
    if (load) begin
      job_nxt   = jq_head;
      busy_nxt  = 1'b1;
      k_nxt     = 3'd0;
      fleft_nxt = jq_head.fffd_cnt;
      if (jq_head.quote_open) begin
        phase_nxt = PH_OPEN;
      end else if (jq_head.fffd_cnt != 3'd0) begin
        phase_nxt = PH_FFFD;
      end else begin
        phase_nxt = PH_TAIL;
      end
    end else if (emit && last) begin
      busy_nxt = 1'b0;
    end else if (emit) begin
      unique case (phase_r)
        PH_OPEN: begin
          k_nxt     = 3'd0;
          phase_nxt = (job_r.fffd_cnt != 3'd0) ? PH_FFFD : PH_TAIL;
        end
        PH_FFFD: begin
          if (k_r == 3'd5) begin
            k_nxt     = 3'd0;
            fleft_nxt = fleft_r - 3'd1;
            if (fleft_r == 3'd1) begin
              phase_nxt = PH_TAIL;
            end
          end else begin
            k_nxt = k_r + 3'd1;
          end
        end
        default: begin
          k_nxt = k_r + 3'd1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      phase_r <= PH_OPEN;
      k_r     <= 3'd0;
      fleft_r <= 3'd0;
    end else begin
      busy_r  <= busy_nxt;
      phase_r <= phase_nxt;
      k_r     <= k_nxt;
      fleft_r <= fleft_nxt;
    end
  end

  always_ff @(posedge clk) begin
    job_r <= job_nxt;
  end

  assign do_opop         = out_pop && (ocnt_r != 2'd0);
  assign out_empty       = ocnt_r == 2'd0;
  assign out_out_byte    = ob_byte_r[ord_r];
  assign out_last_of_run = ob_last_r[ord_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      owr_r  <= 1'b0;
      ord_r  <= 1'b0;
      ocnt_r <= 2'd0;
    end else begin
      if (emit) begin
        owr_r <= !owr_r;
      end
      if (do_opop) begin
        ord_r <= !ord_r;
      end
      if (emit && !do_opop) begin
        ocnt_r <= ocnt_r + 2'd1;
      end else if (do_opop && !emit) begin
        ocnt_r <= ocnt_r - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      ob_byte_r[owr_r] <= ebyte;
      ob_last_r[owr_r] <= last;
    end
  end

`ifndef SYNTHESIS
  a_obuf_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ocnt_r <= 2'd2)
    else $error("output buffer overfilled");

  a_fffd_left: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && phase_r == PH_FFFD) |-> (fleft_r != 3'd0 && k_r <= 3'd5))
    else $error("replacement phase with nothing left to send");

  a_tail_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && phase_r == PH_TAIL) |-> (tlen != 3'd0 && k_r < tlen))
    else $error("tail phase beyond the tail length");
`endif

endmodule

@@ hw/rtl/json_string_escaper_utf8_core.sv @@
// JSON string escaper with UTF-8 validation. Each input transaction carries one
// byte of a string (in_action low) or marks its end (in_action high); the block
// writes the string out as a quoted JSON literal, one byte per output
// transaction, with out_last_of_run set on the final byte caused by an input
// transaction. An input byte that only opens or extends a UTF-8 sequence
// produces no output, unless it is the first byte of a string, which still
// brings the opening quote. The front end classifies each input transaction in the
// cycle it is accepted and queues a compact job if it has output; the back end
// expands one job into bytes at one byte per cycle while the output buffer has
// room, so the sustained rate is one input transaction per cycle while every
// byte maps to one output byte and out_pop keeps up, and otherwise is set by
// the total output length. The job queue of JOB_DEPTH entries lets the input
// side run ahead during long escapes; in_full rises when it fills. An accepted
// byte passes through the job queue, the back end's job register and the
// output buffer before its first output byte appears.
module json_string_escaper_utf8_core
  import jse_pkg::*;
#(
  parameter int JOB_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_push,
  output logic       in_full,
  input  logic       in_action,
  input  logic [7:0] in_data_byte,
  output logic       out_empty,
  input  logic       out_pop,
  output logic [7:0] out_out_byte,
  output logic       out_last_of_run
);

  // Front end to queue.
  logic jq_push;
  job_t jq_job;
  logic jq_full;

  // Queue to back end.
  logic jq_pop;
  logic jq_empty;
  job_t jq_head;

  // The input side stalls only when the job queue has no free slot.
  assign in_full = jq_full;

  jse_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_push      (in_push),
    .in_action    (in_action),
    .in_data_byte (in_data_byte),
    .jq_full      (jq_full),
    .jq_push      (jq_push),
    .jq_job       (jq_job)
  );

  jse_jobq #(
    .DEPTH (JOB_DEPTH)
  ) u_jobq (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (jq_push),
    .push_job (jq_job),
    .full     (jq_full),
    .pop      (jq_pop),
    .head_job (jq_head),
    .empty    (jq_empty)
  );

  // The back end owns the two-entry output buffer, so one byte waiting for out_pop
  // does not block the expansion of the next job; a full buffer does.
  jse_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .jq_empty        (jq_empty),
    .jq_head         (jq_head),
    .jq_pop          (jq_pop),
    .out_pop         (out_pop),
    .out_empty       (out_empty),
    .out_out_byte    (out_out_byte),
    .out_last_of_run (out_last_of_run)
  );

endmodule
